// ===== sv/dsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force package
// Widths, payload structs and the per-cell state carried along the chains.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int DW       = 32;            // data width of positions and forces
  localparam int FB       = 16;            // fraction bits
  localparam int CW       = 31;            // configuration register width
  localparam int DIFF_W   = DW + 1;        // exact difference of two inputs
  localparam int SQ_W     = 2 * DIFF_W;    // squared length and dot product
  localparam int LEN_W    = DIFF_W;        // spring length
  localparam int SQ_REM_W = LEN_W + 2;     // square root partial remainder
  localparam int PROJ_W   = LEN_W + 2;     // velocity projection
  localparam int SPR_W    = CW + LEN_W;    // stiffness term
  localparam int DMP_W    = CW + PROJ_W;   // damping term
  localparam int M_W      = DMP_W + 1;     // force magnitude
  localparam int M_LO_W   = 34;            // low slice of the magnitude product
  localparam int NUM_W    = M_W + DIFF_W;  // component numerator
  localparam int QF_HI    = M_W + 1;       // quotient bits before the shift
  localparam int QF_W     = QF_HI - FB;    // quotient bits that are kept

  localparam int SQ_CELLS = LEN_W;
  localparam int PJ_CELLS = PROJ_W;
  localparam int FC_CELLS = QF_W;

  localparam logic [1:0] REG_REST_LENGTH = 2'd0;
  localparam logic [1:0] REG_STIFFNESS   = 2'd1;
  localparam logic [1:0] REG_DAMPING     = 2'd2;

  typedef struct packed {
    logic signed [DW-1:0] pos_a_x;
    logic signed [DW-1:0] pos_a_y;
    logic signed [DW-1:0] pos_a_z;
    logic signed [DW-1:0] pos_b_x;
    logic signed [DW-1:0] pos_b_y;
    logic signed [DW-1:0] pos_b_z;
    logic signed [DW-1:0] vel_a_x;
    logic signed [DW-1:0] vel_a_y;
    logic signed [DW-1:0] vel_a_z;
    logic signed [DW-1:0] vel_b_x;
    logic signed [DW-1:0] vel_b_y;
    logic signed [DW-1:0] vel_b_z;
  } dsf_in_t;

  typedef struct packed {
    logic signed [DW-1:0] force_a_x;
    logic signed [DW-1:0] force_a_y;
    logic signed [DW-1:0] force_a_z;
    logic signed [DW-1:0] force_b_x;
    logic signed [DW-1:0] force_b_y;
    logic signed [DW-1:0] force_b_z;
    logic                 zero_length;
    logic                 saturated;
  } dsf_out_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic                   zero;
    logic                   dot_neg;
    logic [SQ_W-1:0]        dotm;
  } dsf_geo_t;

  typedef struct packed {
    logic                valid;
    logic [SQ_W-1:0]     rad;
    logic [SQ_REM_W-1:0] rem;
    logic [LEN_W-1:0]    root;
    dsf_geo_t            geo;
  } dsf_sq_t;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   num;
    logic [LEN_W-1:0]  rem;
    logic [PROJ_W-1:0] q;
    logic [LEN_W-1:0]  len;
    dsf_geo_t          geo;
  } dsf_pj_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][QF_HI-1:0]  num;
    logic [2:0][LEN_W-1:0]  rem;
    logic [2:0][QF_W-1:0]   q;
    logic [LEN_W-1:0]       len;
    logic [2:0]             neg;
    logic                   zero;
  } dsf_fc_t;

endpackage

// ===== sv/dsf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring front end
// Differences, products and sums that feed the square root chain.
// ----------------------------------------------------------------------------
module dsf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  dsf_pkg::dsf_in_t in_data_i,
  output dsf_pkg::dsf_sq_t sq_o
);
  import dsf_pkg::*;

  typedef struct packed {
    logic                   valid;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic [2:0][DIFF_W-1:0] vmag;
    logic [2:0]             vneg;
  } f0_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic [2:0][SQ_W-1:0]   sqp;
    logic [2:0][SQ_W-1:0]   dvp;
    logic [2:0]             pneg;
  } f1_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic [SQ_W-1:0]        sq;
    logic [SQ_W-1:0]        dpos;
    logic [SQ_W-1:0]        dngs;
  } f2_t;

  f0_t     f0_d, f0_q;
  f1_t     f1_d, f1_q;
  f2_t     f2_d, f2_q;
  dsf_sq_t sq_d, sq_q;

  logic [2:0][DW-1:0] pa, pb, va, vb;
  logic [2:0][DIFF_W-1:0] dd, vd;

  assign pa = {in_data_i.pos_a_z, in_data_i.pos_a_y, in_data_i.pos_a_x};
  assign pb = {in_data_i.pos_b_z, in_data_i.pos_b_y, in_data_i.pos_b_x};
  assign va = {in_data_i.vel_a_z, in_data_i.vel_a_y, in_data_i.vel_a_x};
  assign vb = {in_data_i.vel_b_z, in_data_i.vel_b_y, in_data_i.vel_b_x};

  always_comb begin
    f0_d.valid = in_valid_i;
    for (int i = 0; i < 3; i++) begin
      dd[i] = {pa[i][DW-1], pa[i]} - {pb[i][DW-1], pb[i]};
      vd[i] = {va[i][DW-1], va[i]} - {vb[i][DW-1], vb[i]};
      f0_d.dneg[i] = dd[i][DIFF_W-1];
      f0_d.vneg[i] = vd[i][DIFF_W-1];
      f0_d.dmag[i] = dd[i][DIFF_W-1] ? (~dd[i] + 1'b1) : dd[i];
      f0_d.vmag[i] = vd[i][DIFF_W-1] ? (~vd[i] + 1'b1) : vd[i];
    end
  end

  always_comb begin
    f1_d.valid = f0_q.valid;
    f1_d.dmag  = f0_q.dmag;
    f1_d.dneg  = f0_q.dneg;
    for (int i = 0; i < 3; i++) begin
      f1_d.sqp[i]  = f0_q.dmag[i] * f0_q.dmag[i];
      f1_d.dvp[i]  = f0_q.dmag[i] * f0_q.vmag[i];
      f1_d.pneg[i] = f0_q.dneg[i] ^ f0_q.vneg[i];
    end
  end

  always_comb begin
    f2_d.valid = f1_q.valid;
    f2_d.dmag  = f1_q.dmag;
    f2_d.dneg  = f1_q.dneg;
    f2_d.sq    = f1_q.sqp[0] + f1_q.sqp[1] + f1_q.sqp[2];
    f2_d.dpos  = '0;
    f2_d.dngs  = '0;
    for (int i = 0; i < 3; i++) begin
      if (f1_q.pneg[i]) begin
        f2_d.dngs = f2_d.dngs + f1_q.dvp[i];
      end else begin
        f2_d.dpos = f2_d.dpos + f1_q.dvp[i];
      end
    end
  end

  always_comb begin
    sq_d.valid       = f2_q.valid;
    sq_d.rad         = f2_q.sq;
    sq_d.rem         = '0;
    sq_d.root        = '0;
    sq_d.geo.dmag    = f2_q.dmag;
    sq_d.geo.dneg    = f2_q.dneg;
    sq_d.geo.zero    = (f2_q.sq == '0);
    sq_d.geo.dot_neg = (f2_q.dpos < f2_q.dngs);
    sq_d.geo.dotm    = sq_d.geo.dot_neg ? (f2_q.dngs - f2_q.dpos) : (f2_q.dpos - f2_q.dngs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q <= '0;
      f1_q <= '0;
      f2_q <= '0;
      sq_q <= '0;
    end else if (en_i) begin
      f0_q <= f0_d;
      f1_q <= f1_d;
      f2_q <= f2_d;
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== sv/dsf_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring square root cell
// Resolves one bit of the integer square root per cell, two radicand bits in.
// ----------------------------------------------------------------------------
module dsf_sqrt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsf_pkg::dsf_sq_t cell_i,
  output dsf_pkg::dsf_sq_t cell_o
);
  import dsf_pkg::*;

  dsf_sq_t             cell_d, cell_q;
  logic [SQ_REM_W-1:0] rem_sh, trial;
  logic                take;

  always_comb begin
    rem_sh = {cell_i.rem[SQ_REM_W-3:0], cell_i.rad[SQ_W-1 -: 2]};
    trial  = SQ_REM_W'({cell_i.root[LEN_W-2:0], 2'b01});
    take   = (rem_sh >= trial);
    cell_d       = cell_i;
    cell_d.rad   = {cell_i.rad[SQ_W-3:0], 2'b00};
    cell_d.rem   = take ? (rem_sh - trial) : rem_sh;
    cell_d.root  = {cell_i.root[LEN_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== sv/dsf_proj_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring projection cell
// One restoring division step of the dot product by the spring length.
// ----------------------------------------------------------------------------
module dsf_proj_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsf_pkg::dsf_pj_t cell_i,
  output dsf_pkg::dsf_pj_t cell_o
);
  import dsf_pkg::*;

  dsf_pj_t        cell_d, cell_q;
  logic [LEN_W:0] sh;
  logic           take;

  always_comb begin
    sh   = {cell_i.rem, cell_i.num[SQ_W-1]};
    take = (sh >= {1'b0, cell_i.len});
    cell_d     = cell_i;
    cell_d.num = {cell_i.num[SQ_W-2:0], 1'b0};
    cell_d.rem = take ? LEN_W'(sh - {1'b0, cell_i.len}) : LEN_W'(sh);
    cell_d.q   = {cell_i.q[PROJ_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== sv/dsf_force_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force cell
// One restoring division step for all three force components at once.
// ----------------------------------------------------------------------------
module dsf_force_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsf_pkg::dsf_fc_t cell_i,
  output dsf_pkg::dsf_fc_t cell_o
);
  import dsf_pkg::*;

  dsf_fc_t              cell_d, cell_q;
  logic [2:0][LEN_W:0]  sh;
  logic [2:0]           take;

  always_comb begin
    cell_d = cell_i;
    for (int i = 0; i < 3; i++) begin
      sh[i]   = {cell_i.rem[i], cell_i.num[i][QF_HI-1]};
      take[i] = (sh[i] >= {1'b0, cell_i.len});
      cell_d.num[i] = {cell_i.num[i][QF_HI-2:0], 1'b0};
      cell_d.rem[i] = take[i] ? LEN_W'(sh[i] - {1'b0, cell_i.len}) : LEN_W'(sh[i]);
      cell_d.q[i]   = {cell_i.q[i][QF_W-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== sv/damped_spring_force_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force core
// Damped Hooke force between two particles in Q16.16, saturated results.
// ----------------------------------------------------------------------------
// The core accepts one spring item per clock while it is not held, and passes it
// through four front stages, a 33-cell square root chain, a 35-cell projection
// divider, four stages that form the force magnitude, a 52-cell component
// divider and the output register. All stages advance together; they hold
// only while a finished result waits at the output.
module damped_spring_force_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsf_pkg::dsf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsf_pkg::dsf_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [dsf_pkg::CW-1:0] cfg_data_i
);
  import dsf_pkg::*;

  typedef struct packed {
    logic                   valid;
    logic [LEN_W-1:0]       st;
    logic                   st_neg;
    logic [PROJ_W-1:0]      proj;
    logic                   dot_neg;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic                   zero;
    logic [LEN_W-1:0]       len;
  } m1_t;

  typedef struct packed {
    logic                   valid;
    logic [SPR_W-1:0]       spring;
    logic [DMP_W-1:0]       damp;
    logic                   st_neg;
    logic                   dot_neg;
    logic [2:0][DIFF_W-1:0] dmag;
    logic [2:0]             dneg;
    logic                   zero;
    logic [LEN_W-1:0]       len;
  } m2_t;

  typedef struct packed {
    logic                   valid;
    logic [M_W-1:0]         mag;
    logic [2:0]             neg;
    logic [2:0][DIFF_W-1:0] dmag;
    logic                   zero;
    logic [LEN_W-1:0]       len;
  } m3_t;

  typedef struct packed {
    logic                          valid;
    logic [2:0][M_LO_W+DIFF_W-1:0] p_lo;
    logic [2:0][M_W-M_LO_W+DIFF_W-1:0] p_hi;
    logic [2:0]                    neg;
    logic                          zero;
    logic [LEN_W-1:0]              len;
  } m4_t;

  localparam logic [QF_W-1:0] SAT_LIM = QF_W'(1) << (DW - 1);
  localparam logic [DW-1:0]   MIN_V   = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]   MAX_V   = {1'b0, {(DW-1){1'b1}}};

  logic en;
  logic [CW-1:0] rest_q, stiff_q, damp_q;

  dsf_sq_t sq_chain [SQ_CELLS+1];
  dsf_pj_t pj_chain [PJ_CELLS+1];
  dsf_fc_t fc_chain [FC_CELLS+1];
  dsf_pj_t pj_head;
  dsf_fc_t fc_head;

  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  m3_t m3_d, m3_q;
  m4_t m4_d, m4_q;

  logic     out_valid_q;
  dsf_out_t out_d, out_q;

  logic [M_W-1:0]   sum_m, sd_m, ds_m;
  logic [NUM_W-1:0] numer [3];
  logic [DW:0]      sat_a [3];
  logic [DW:0]      sat_b [3];

  function automatic logic [DW:0] sat_f(input logic [QF_W-1:0] q, input logic neg);
    logic          clamp;
    logic [DW-1:0] val;
    if (neg) begin
      clamp = (q > SAT_LIM);
      val   = clamp ? MIN_V : DW'(~q[DW-1:0] + 1'b1);
    end else begin
      clamp = (q > (SAT_LIM - 1'b1));
      val   = clamp ? MAX_V : q[DW-1:0];
    end
    return {clamp, val};
  endfunction

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= CW'(65536);
      stiff_q <= CW'(65536);
      damp_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REST_LENGTH: rest_q  <= cfg_data_i;
        REG_STIFFNESS:   stiff_q <= cfg_data_i;
        REG_DAMPING:     damp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .sq_o       (sq_chain[0])
  );

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
    dsf_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sq_chain[g]),
      .cell_o (sq_chain[g+1])
    );
  end

  // The dot product enters the divider with its upper bits already in the
  // remainder; the projection is known to fit in PROJ_W bits.
  always_comb begin
    pj_head.valid = sq_chain[SQ_CELLS].valid;
    pj_head.num   = sq_chain[SQ_CELLS].geo.dotm << (SQ_W - PROJ_W);
    pj_head.rem   = LEN_W'(sq_chain[SQ_CELLS].geo.dotm[SQ_W-1:PROJ_W]);
    pj_head.q     = '0;
    pj_head.len   = sq_chain[SQ_CELLS].root;
    pj_head.geo   = sq_chain[SQ_CELLS].geo;
  end

  assign pj_chain[0] = pj_head;

  for (genvar g = 0; g < PJ_CELLS; g++) begin : g_proj
    dsf_proj_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (pj_chain[g]),
      .cell_o (pj_chain[g+1])
    );
  end

  always_comb begin
    m1_d.valid   = pj_chain[PJ_CELLS].valid;
    m1_d.len     = pj_chain[PJ_CELLS].len;
    m1_d.st_neg  = (LEN_W'(rest_q) > m1_d.len);
    m1_d.st      = m1_d.st_neg ? (LEN_W'(rest_q) - m1_d.len) : (m1_d.len - LEN_W'(rest_q));
    m1_d.proj    = pj_chain[PJ_CELLS].q;
    m1_d.dot_neg = pj_chain[PJ_CELLS].geo.dot_neg;
    m1_d.dmag    = pj_chain[PJ_CELLS].geo.dmag;
    m1_d.dneg    = pj_chain[PJ_CELLS].geo.dneg;
    m1_d.zero    = pj_chain[PJ_CELLS].geo.zero;
  end

  always_comb begin
    m2_d.valid   = m1_q.valid;
    m2_d.spring  = stiff_q * m1_q.st;
    m2_d.damp    = damp_q * m1_q.proj;
    m2_d.st_neg  = m1_q.st_neg;
    m2_d.dot_neg = m1_q.dot_neg;
    m2_d.dmag    = m1_q.dmag;
    m2_d.dneg    = m1_q.dneg;
    m2_d.zero    = m1_q.zero;
    m2_d.len     = m1_q.len;
  end

  always_comb begin
    logic m_neg;
    sum_m = M_W'(m2_q.spring) + M_W'(m2_q.damp);
    sd_m  = M_W'(m2_q.spring) - M_W'(m2_q.damp);
    ds_m  = M_W'(m2_q.damp) - M_W'(m2_q.spring);
    if (m2_q.st_neg == m2_q.dot_neg) begin
      m3_d.mag = sum_m;
      m_neg    = m2_q.st_neg;
    end else if (M_W'(m2_q.spring) >= M_W'(m2_q.damp)) begin
      m3_d.mag = sd_m;
      m_neg    = m2_q.st_neg;
    end else begin
      m3_d.mag = ds_m;
      m_neg    = m2_q.dot_neg;
    end
    m3_d.valid = m2_q.valid;
    for (int i = 0; i < 3; i++) begin
      m3_d.neg[i] = !(m_neg ^ m2_q.dneg[i]);
    end
    m3_d.dmag = m2_q.dmag;
    m3_d.zero = m2_q.zero;
    m3_d.len  = m2_q.len;
  end

  // The wide magnitude is multiplied in two slices and recombined below.
  always_comb begin
    m4_d.valid = m3_q.valid;
    for (int i = 0; i < 3; i++) begin
      m4_d.p_lo[i] = m3_q.mag[M_LO_W-1:0] * m3_q.dmag[i];
      m4_d.p_hi[i] = m3_q.mag[M_W-1:M_LO_W] * m3_q.dmag[i];
    end
    m4_d.neg  = m3_q.neg;
    m4_d.zero = m3_q.zero;
    m4_d.len  = m3_q.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
    end else if (en) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      m3_q <= m3_d;
      m4_q <= m4_d;
    end
  end

  always_comb begin
    fc_head.valid = m4_q.valid;
    fc_head.len   = m4_q.len;
    fc_head.neg   = m4_q.neg;
    fc_head.zero  = m4_q.zero;
    for (int i = 0; i < 3; i++) begin
      numer[i] = NUM_W'(m4_q.p_lo[i]) + (NUM_W'(m4_q.p_hi[i]) << M_LO_W);
      fc_head.rem[i] = LEN_W'(numer[i][NUM_W-1:QF_HI]);
      fc_head.num[i] = numer[i][QF_HI-1:0];
      fc_head.q[i]   = '0;
    end
  end

  assign fc_chain[0] = fc_head;

  for (genvar g = 0; g < FC_CELLS; g++) begin : g_force
    dsf_force_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (fc_chain[g]),
      .cell_o (fc_chain[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_a[i] = sat_f(fc_chain[FC_CELLS].q[i], fc_chain[FC_CELLS].neg[i]);
      sat_b[i] = sat_f(fc_chain[FC_CELLS].q[i], !fc_chain[FC_CELLS].neg[i]);
    end
    if (fc_chain[FC_CELLS].zero) begin
      out_d = '0;
      out_d.zero_length = 1'b1;
    end else begin
      out_d.force_a_x   = sat_a[0][DW-1:0];
      out_d.force_a_y   = sat_a[1][DW-1:0];
      out_d.force_a_z   = sat_a[2][DW-1:0];
      out_d.force_b_x   = sat_b[0][DW-1:0];
      out_d.force_b_y   = sat_b[1][DW-1:0];
      out_d.force_b_z   = sat_b[2][DW-1:0];
      out_d.zero_length = 1'b0;
      out_d.saturated   = sat_a[0][DW] | sat_a[1][DW] | sat_a[2][DW] |
                          sat_b[0][DW] | sat_b[1][DW] | sat_b[2][DW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (en) begin
      out_valid_q <= fc_chain[FC_CELLS].valid;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      out_data_o.force_a_x == '0 && out_data_o.force_a_y == '0 &&
      out_data_o.force_a_z == '0 && !out_data_o.saturated)
    else $error("coinciding particles gave a nonzero force");

  a_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.saturated |->
      DW'(out_data_o.force_a_x + out_data_o.force_b_x) == '0 &&
      DW'(out_data_o.force_a_y + out_data_o.force_b_y) == '0 &&
      DW'(out_data_o.force_a_z + out_data_o.force_b_z) == '0)
    else $error("unclamped forces are not opposite");

  a_proj_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pj_chain[PJ_CELLS].valid && !pj_chain[PJ_CELLS].geo.zero |->
      pj_chain[PJ_CELLS].rem < pj_chain[PJ_CELLS].len)
    else $error("projection remainder not below the length");

  a_force_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_chain[FC_CELLS].valid && !fc_chain[FC_CELLS].zero |->
      fc_chain[FC_CELLS].rem[0] < fc_chain[FC_CELLS].len &&
      fc_chain[FC_CELLS].rem[1] < fc_chain[FC_CELLS].len &&
      fc_chain[FC_CELLS].rem[2] < fc_chain[FC_CELLS].len)
    else $error("force remainder not below the length");

endmodule

// ===== bench/damped_spring_force_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force core testbench
// Streams spring items through the core under several register settings. Each
// accepted item is turned into an expected force set by an exact wide-integer
// model of the spring law, and every result is compared field by field.
// ----------------------------------------------------------------------------
module damped_spring_force_core_tb;
  import dsf_pkg::*;

  localparam int DRAIN_CYCLES = 160;
  localparam int WATCHDOG_MAX = 4000;
  localparam int LATE_ITEMS   = 950;

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [CW-1:0] val;
    dsf_in_t    item;
  } job_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_valid_i, cfg_ready_o;
  dsf_in_t in_data_i;
  dsf_out_t out_data_o;
  logic [1:0] cfg_index_i;
  logic [CW-1:0] cfg_data_i;

  job_t job_q[$];
  dsf_out_t force_q[$];
  logic signed [127:0] rest_len, stiff, damp;
  int items_sent, results_seen, zero_seen, sat_seen, errors, quiet_cnt, idle_cycles;
  int gap_cnt, stall_cnt;
  bit finished;

  damped_spring_force_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Exact force on both particles for one item under the current registers.
  function automatic dsf_out_t spring_force(dsf_in_t s);
    logic signed [31:0] pa[3], pb[3], va[3], vb[3];
    logic signed [33:0] d[3], v[3];
    logic [33:0] dm[3];
    logic [127:0] sq, len, c, proj;
    logic signed [127:0] dot, dotm, m, mmag;
    logic [191:0] num, q;
    logic [31:0] fa[3], fb[3];
    logic neg, clamp;
    dsf_out_t r;
    pa = '{s.pos_a_x, s.pos_a_y, s.pos_a_z};
    pb = '{s.pos_b_x, s.pos_b_y, s.pos_b_z};
    va = '{s.vel_a_x, s.vel_a_y, s.vel_a_z};
    vb = '{s.vel_b_x, s.vel_b_y, s.vel_b_z};
    sq = '0;
    dot = '0;
    clamp = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = pa[i] - pb[i];
      v[i] = va[i] - vb[i];
      dm[i] = d[i] < 0 ? -d[i] : d[i];
      sq = sq + dm[i] * dm[i];
      dot = dot + d[i] * v[i];
    end
    r = '0;
    if (sq == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      c = len | (128'd1 << b);
      if (c * c <= sq) len = c;
    end
    dotm = dot < 0 ? -dot : dot;
    proj = dotm / len;
    m = stiff * ($signed(len) - rest_len);
    m = dot < 0 ? m - damp * $signed(proj) : m + damp * $signed(proj);
    mmag = m < 0 ? -m : m;
    for (int i = 0; i < 3; i++) begin
      num = mmag * dm[i];
      q = (num / len) >> FB;
      // The force on the first particle points against m * d.
      neg = (m < 0) == (d[i] < 0);
      if (neg) begin
        if (q > 192'h8000_0000) begin fa[i] = 32'h8000_0000; clamp = 1'b1; end
        else fa[i] = -q[31:0];
        if (q > 192'h7fff_ffff) begin fb[i] = 32'h7fff_ffff; clamp = 1'b1; end
        else fb[i] = q[31:0];
      end else begin
        if (q > 192'h7fff_ffff) begin fa[i] = 32'h7fff_ffff; clamp = 1'b1; end
        else fa[i] = q[31:0];
        if (q > 192'h8000_0000) begin fb[i] = 32'h8000_0000; clamp = 1'b1; end
        else fb[i] = -q[31:0];
      end
    end
    r.force_a_x = fa[0]; r.force_a_y = fa[1]; r.force_a_z = fa[2];
    r.force_b_x = fb[0]; r.force_b_y = fb[1]; r.force_b_z = fb[2];
    r.saturated = clamp;
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      1: return $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic dsf_in_t rnd_item();
    dsf_in_t s;
    int mode, kind;
    kind = $urandom_range(0, 9);
    mode = kind < 5 ? 0 : (kind < 8 ? 1 : 2);
    s.pos_a_x = rnd_coord(mode); s.pos_a_y = rnd_coord(mode); s.pos_a_z = rnd_coord(mode);
    s.pos_b_x = rnd_coord(mode); s.pos_b_y = rnd_coord(mode); s.pos_b_z = rnd_coord(mode);
    s.vel_a_x = rnd_coord(mode); s.vel_a_y = rnd_coord(mode); s.vel_a_z = rnd_coord(mode);
    s.vel_b_x = rnd_coord(mode); s.vel_b_y = rnd_coord(mode); s.vel_b_z = rnd_coord(mode);
    if (kind == 9) begin
      s.pos_b_x = s.pos_a_x; s.pos_b_y = s.pos_a_y; s.pos_b_z = s.pos_a_z;
    end else if ($urandom_range(0, 9) == 0) begin
      s.pos_b_y = s.pos_a_y; s.pos_b_z = s.pos_a_z;
    end
    return s;
  endfunction

  task automatic add_item(dsf_in_t s);
    job_t j;
    j = '{is_cfg: 1'b0, idx: '0, val: '0, item: s};
    job_q.push_back(j);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [CW-1:0] val);
    job_t j;
    j = '{is_cfg: 1'b1, idx: idx, val: val, item: '0};
    job_q.push_back(j);
  endtask

  task automatic add_directed();
    dsf_in_t s;
    s = '0;
    add_item(s);
    s.vel_a_x = 32'h7fff_ffff; s.vel_b_x = 32'h8000_0000;
    add_item(s);
    s = '0;
    s.pos_a_x = 32'h0001_0000;
    add_item(s);
    s.pos_a_x = 32'h0002_0000; s.vel_a_x = 32'hffff_0000;
    add_item(s);
    s = '0;
    s.pos_a_x = 32'h7fff_ffff; s.pos_b_x = 32'h8000_0000;
    s.pos_a_y = 32'h7fff_ffff; s.pos_b_y = 32'h8000_0000;
    s.pos_a_z = 32'h8000_0000; s.pos_b_z = 32'h7fff_ffff;
    s.vel_a_x = 32'h8000_0000; s.vel_b_x = 32'h7fff_ffff;
    s.vel_a_y = 32'h7fff_ffff; s.vel_b_y = 32'h8000_0000;
    s.vel_a_z = 32'hffff_ffff; s.vel_b_z = 32'h0000_0000;
    add_item(s);
    s = '1;
    add_item(s);
    s = '0;
    s.pos_b_z = 32'h0000_0001;
    s.vel_a_z = 32'h7fff_ffff;
    add_item(s);
    s = '0;
    s.pos_a_y = 32'hfffe_0000; s.vel_b_y = 32'h0003_0000;
    add_item(s);
    for (int i = 0; i < 6; i++) add_item(rnd_item());
  endtask

  // Item stream: a directed set at reset values, then phases of register
  // settings, each followed by random traffic and, in the first two, the directed set.
  initial begin
    logic [CW-1:0] cfg_set[8][3];
    cfg_set[0] = '{31'h0000_0000, 31'h7fff_ffff, 31'h7fff_ffff};
    cfg_set[1] = '{31'h7fff_ffff, 31'h0000_0000, 31'h0000_0000};
    cfg_set[2] = '{31'h0002_0000, 31'h0000_8000, 31'h0000_4000};
    cfg_set[3] = '{31'h7fff_ffff, 31'h7fff_ffff, 31'h0000_0000};
    cfg_set[4] = '{31'h0000_0000, 31'h0000_0000, 31'h7fff_ffff};
    cfg_set[5] = '{CW'($urandom), CW'($urandom), CW'($urandom)};
    cfg_set[6] = '{CW'($urandom_range(0, 32'h000f_ffff)),
                   CW'($urandom_range(0, 32'h000f_ffff)),
                   CW'($urandom_range(0, 32'h000f_ffff))};
    cfg_set[7] = '{31'h0001_0000, 31'h0001_0000, 31'h0001_0000};
    in_valid_i = 1'b0; in_data_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    out_ready_i = 1'b0;
    rst_ni = 1'b0;
    add_directed();
    for (int p = 0; p < 8; p++) begin
      add_cfg(REG_REST_LENGTH, cfg_set[p][0]);
      add_cfg(REG_STIFFNESS, cfg_set[p][1]);
      add_cfg(REG_DAMPING, cfg_set[p][2]);
      // An index past the register file must leave every register alone.
      if (p == 2) add_cfg(2'd3, CW'($urandom));
      if (p < 2) add_directed();
      for (int i = 0; i < 125; i++) add_item(rnd_item());
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (job_q.size() != 0 || in_valid_i || cfg_valid_i || force_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    finished = 1'b1;
    $display("Checked %0d results over %0d items and 8 register settings", results_seen,
             items_sent);
    $display("%0d coinciding springs, %0d saturated results", zero_seen, sat_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Driver: input and register channels share one ordered stream of jobs.
  always @(posedge clk_i or negedge rst_ni) begin
    bit in_hold, cfg_hold;
    job_t j;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_cnt <= 0;
      quiet_cnt <= 0;
    end else begin
      in_hold = in_valid_i && !in_ready_o;
      cfg_hold = cfg_valid_i && !cfg_ready_o;
      if ((in_valid_i && in_ready_o) || force_q.size() != 0) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (in_valid_i && in_ready_o) items_sent <= items_sent + 1;
      if (!in_hold && !cfg_hold) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid_i <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (items_sent < LATE_ITEMS && $urandom_range(0, 7) == 0) begin
          gap_cnt <= $urandom_range(0, 14);
          in_valid_i <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (job_q.size() == 0) begin
          in_valid_i <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (job_q[0].is_cfg) begin
          in_valid_i <= 1'b0;
          // Register writes wait until the pipeline has fully drained.
          if (quiet_cnt >= DRAIN_CYCLES && !(in_valid_i && in_ready_o)) begin
            j = job_q.pop_front();
            cfg_valid_i <= 1'b1;
            cfg_index_i <= j.idx;
            cfg_data_i <= j.val;
          end else begin
            cfg_valid_i <= 1'b0;
          end
        end else begin
          j = job_q.pop_front();
          cfg_valid_i <= 1'b0;
          in_valid_i <= 1'b1;
          in_data_i <= j.item;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (items_sent < LATE_ITEMS && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on accepted items, tracks registers, checks results.
  always @(posedge clk_i) begin
    dsf_out_t want;
    logic [31:0] w[8], g[8];
    string names[8];
    names = '{"force_a_x", "force_a_y", "force_a_z", "force_b_x", "force_b_y",
              "force_b_z", "zero_length", "saturated"};
    if (!rst_ni) begin
      rest_len <= 128'd65536;
      stiff <= 128'd65536;
      damp <= 128'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_REST_LENGTH: rest_len <= 128'(cfg_data_i);
          REG_STIFFNESS:   stiff <= 128'(cfg_data_i);
          REG_DAMPING:     damp <= 128'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) force_q.push_back(spring_force(in_data_i));
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (out_data_o.zero_length) zero_seen <= zero_seen + 1;
        if (out_data_o.saturated) sat_seen <= sat_seen + 1;
        if (force_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
          errors <= errors + 1;
        end else begin
          want = force_q.pop_front();
          w = '{want.force_a_x, want.force_a_y, want.force_a_z, want.force_b_x,
                want.force_b_y, want.force_b_z, want.zero_length, want.saturated};
          g = '{out_data_o.force_a_x, out_data_o.force_a_y, out_data_o.force_a_z,
                out_data_o.force_b_x, out_data_o.force_b_y, out_data_o.force_b_z,
                out_data_o.zero_length, out_data_o.saturated};
          for (int i = 0; i < 8; i++) begin
            if (w[i] !== g[i]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, names[i], w[i],
                       g[i]);
              errors <= errors + 1;
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX && !finished) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
